[rtl/core/assert_macros.svh]
// shared assertion shorthands for the rejection sampler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define MQRS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define MQRS_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/mqrs_pkg.sv]
package mqrs_pkg;

    localparam int NUM_CAND   = 8;
    localparam int CAND_W     = 24;
    localparam int COEF_W     = 23;
    localparam int BOUND_W    = 24;
    localparam int NCAND_W    = 4;
    localparam int INDEX_W    = 8;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [COEF_W-1:0]  CAND_MASK   = 23'h7FFFFF;
    localparam logic [BOUND_W-1:0] BOUND_RESET = 24'd8380417;

    // register index decoded from paddr[2]
    typedef enum logic {
        REG_BOUND = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [CAND_W-1:0]  candidate_0;
        logic [CAND_W-1:0]  candidate_1;
        logic [CAND_W-1:0]  candidate_2;
        logic [CAND_W-1:0]  candidate_3;
        logic [CAND_W-1:0]  candidate_4;
        logic [CAND_W-1:0]  candidate_5;
        logic [CAND_W-1:0]  candidate_6;
        logic [CAND_W-1:0]  candidate_7;
        logic [NCAND_W-1:0] valid_candidates;
        logic               new_polynomial;
    } cand_item_t;

    typedef struct packed {
        logic [COEF_W-1:0]  coefficient;
        logic [INDEX_W-1:0] coeff_index;
        logic               run_last;
        logic               poly_done;
    } coef_item_t;

    // drain stage status toward the top level
    typedef struct packed {
        logic emit;   // a coefficient leaves the drain this cycle
        logic free;   // the item register can take a new request
    } drain_stat_t;

endpackage

[rtl/core/mqrs_screen.sv]
module mqrs_screen #(
    parameter int LANES = 8
) (
    input  mqrs_pkg::cand_item_t           item,
    input  logic [mqrs_pkg::BOUND_W-1:0]   bound,
    output logic [LANES-1:0]               keep,
    output logic [mqrs_pkg::COEF_W-1:0]    vals [LANES]
);
    import mqrs_pkg::*;

    logic [CAND_W-1:0] cands [NUM_CAND];

    assign cands[0] = item.candidate_0;
    assign cands[1] = item.candidate_1;
    assign cands[2] = item.candidate_2;
    assign cands[3] = item.candidate_3;
    assign cands[4] = item.candidate_4;
    assign cands[5] = item.candidate_5;
    assign cands[6] = item.candidate_6;
    assign cands[7] = item.candidate_7;

    // lane index below LANES also clamps an oversized count
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            vals[i] = cands[i][COEF_W-1:0] & CAND_MASK;
            keep[i] = (NCAND_W'(i) < item.valid_candidates)
                      && ({1'b0, vals[i]} < bound);
        end
    end

endmodule

[rtl/core/mqrs_drain.sv]
`include "assert_macros.svh"

module mqrs_drain #(
    parameter int LANES           = 8,
    parameter int COEFFS_PER_POLY = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic                          new_poly,
    input  logic [LANES-1:0]              keep_in,
    input  logic [mqrs_pkg::COEF_W-1:0]   vals_in [LANES],
    input  logic                          slot_open,
    output mqrs_pkg::drain_stat_t         stat,
    output mqrs_pkg::coef_item_t          result
);
    import mqrs_pkg::*;

    localparam int CNT_W = $clog2(COEFFS_PER_POLY + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(COEFFS_PER_POLY);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COEFFS_PER_POLY - 1);

    logic [LANES-1:0]  mask_reg, mask_next;
    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [COEF_W-1:0] vals_reg [LANES];

    logic [LANES-1:0]  low_bit;
    logic [LANES-1:0]  rest;
    logic [COEF_W-1:0] pick;
    logic              full;
    logic              last;
    logic              emit;
    logic              done;

    // lowest kept lane goes first
    assign low_bit = mask_reg & (~mask_reg + LANES'(1));
    assign rest    = mask_reg & ~low_bit;
    assign full    = (count_reg >= CNT_FULL);
    assign last    = (rest == '0) || (count_reg == CNT_LAST);
    assign emit    = busy_reg && !full && slot_open;
    assign done    = busy_reg && (full || (emit && last));

    always_comb
    begin
        pick = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (low_bit[i])
            begin
                pick = pick | vals_reg[i];
            end
        end
    end

    assign result.coefficient = pick;
    assign result.coeff_index = INDEX_W'(count_reg);
    assign result.run_last    = last;
    assign result.poly_done   = (count_reg == CNT_LAST);

    assign stat.emit = emit;
    assign stat.free = !busy_reg || done;

    always_comb
    begin
        mask_next  = mask_reg;
        busy_next  = busy_reg;
        count_next = count_reg;
        if (emit)
        begin
            mask_next  = rest;
            count_next = count_reg + CNT_W'(1);
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            mask_next = keep_in;
            busy_next = |keep_in;
            if (new_poly)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= '0;
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            mask_reg  <= mask_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            vals_reg <= vals_in;
        end
    end

    `MQRS_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_FULL, "accepted count past polynomial size")
    `MQRS_ASSERT_IMPLY(a_emit_has_lane, emit, mask_reg != '0, "emit with no kept lane left")
    `MQRS_ASSERT_IMPLY(a_load_when_free, load, !busy_reg || done, "item register overwritten while busy")

endmodule

[rtl/core/mod_q_rejection_sampler.sv]
// path: a request waits in the drain's item register; its coefficients leave via the output register
// throughput: one coefficient per cycle unless coef_stall holds the output; a request holds
//   the drain while its kept candidates (up to LANES) leave, until the polynomial is full, is
//   cleared without output when the polynomial is already full, and does not hold it when none
//   is kept; the next request enters at the edge where the last coefficient of the current one leaves
// reset: rst_n clears the accepted count, all valid flags and sets the bound to 8380417
`include "assert_macros.svh"

module mod_q_rejection_sampler #(
    parameter int LANES           = 8,
    parameter int COEFFS_PER_POLY = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mqrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mqrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mqrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // candidate requests
    input  logic                              cand_valid,
    output logic                              cand_stall,
    input  mqrs_pkg::cand_item_t              cand_data,
    // coefficient requests
    output logic                              coef_valid,
    input  logic                              coef_stall,
    output mqrs_pkg::coef_item_t              coef_data
);
    import mqrs_pkg::*;

    // acceptance bound register
    logic [BOUND_W-1:0] bound_reg;
    reg_idx_t           reg_sel;
    logic               cfg_write;

    // output register
    logic               out_valid_reg, out_valid_next;
    coef_item_t         out_reg;

    // screening and drain
    logic [LANES-1:0]   keep;
    logic [COEF_W-1:0]  vals [LANES];
    drain_stat_t        stat;
    coef_item_t         result;
    logic               slot_open;
    logic               cand_take;

    // one register; byte address 0, paddr[2] selects it
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= BOUND_RESET;
        end
        else if (cfg_write && (reg_sel == REG_BOUND))
        begin
            bound_reg <= pwdata[BOUND_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BOUND: prdata = APB_DATA_W'(bound_reg);
            default:   prdata = '0;
        endcase
    end

    // the item register takes a request once its current one is drained,
    // even if that happens in this very cycle
    assign cand_stall = !stat.free;
    assign cand_take  = cand_valid && !cand_stall;

    // candidate screening: mask to 23 bits, compare with the bound, count lanes
    mqrs_screen #(
        .LANES (LANES)
    ) u_screen (
        .item  (cand_data),
        .bound (bound_reg),
        .keep  (keep),
        .vals  (vals)
    );

    // output register takes a new coefficient when empty or being read
    assign slot_open = !out_valid_reg || !coef_stall;

    // picks kept lanes in order and tracks the coefficient count
    mqrs_drain #(
        .LANES           (LANES),
        .COEFFS_PER_POLY (COEFFS_PER_POLY)
    ) u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (cand_take),
        .new_poly  (cand_data.new_polynomial),
        .keep_in   (keep),
        .vals_in   (vals),
        .slot_open (slot_open),
        .stat      (stat),
        .result    (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (slot_open)
        begin
            out_valid_next = stat.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.emit)
        begin
            out_reg <= result;
        end
    end

    assign coef_valid = out_valid_reg;
    assign coef_data  = out_reg;

    // the final coefficient of a polynomial always closes its request
    `MQRS_ASSERT_IMPLY(a_done_is_last, out_valid_reg && out_reg.poly_done, out_reg.run_last, "poly_done alone")
    // a coefficient only leaves the drain into a free output slot
    `MQRS_ASSERT_IMPLY(a_emit_into_slot, stat.emit, slot_open, "emit into held slot")
    // the input is only stalled while a coefficient moves or the output is held
    `MQRS_ASSERT_IMPLY(a_stall_needs_work, cand_stall, stat.emit || !slot_open, "idle stall")

endmodule

[tb/sv/mqrs_coef_checker.sv]
`timescale 1ns / 1ps

module mqrs_coef_checker
    import mqrs_pkg::*;
#(
    parameter int LANES           = 8,
    parameter int COEFFS_PER_POLY = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  cand_valid,
    input  logic                  cand_stall,
    input  cand_item_t            cand_data,
    input  logic                  coef_valid,
    input  logic                  coef_stall,
    input  coef_item_t            coef_data,
    output int                    mismatches,
    output int                    outstanding
);

    logic [BOUND_W-1:0] bound_q;
    logic [8:0]         kept_count;
    coef_item_t         coef_expect_q[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // kept coefficients of one candidate request, in lane order
    task automatic predict_coefficients(input cand_item_t req);
        logic [CAND_W-1:0] cand [NUM_CAND];
        coef_item_t        kept [NUM_CAND];
        logic [COEF_W-1:0] v;
        int                lanes;
        int                n;
        cand[0] = req.candidate_0;
        cand[1] = req.candidate_1;
        cand[2] = req.candidate_2;
        cand[3] = req.candidate_3;
        cand[4] = req.candidate_4;
        cand[5] = req.candidate_5;
        cand[6] = req.candidate_6;
        cand[7] = req.candidate_7;
        lanes = int'(req.valid_candidates);
        if (lanes > LANES)
        begin
            lanes = LANES;
        end
        n = 0;
        if (req.new_polynomial)
        begin
            kept_count = '0;
        end
        for (int i = 0; i < lanes; i++)
        begin
            v = cand[i][COEF_W-1:0] & CAND_MASK;
            // the count never drops, so a full polynomial drops the rest
            if (kept_count < COEFFS_PER_POLY && v < bound_q)
            begin
                kept[n].coefficient = v;
                kept[n].coeff_index = kept_count[INDEX_W-1:0];
                kept[n].run_last    = 1'b0;
                kept[n].poly_done   = (kept_count + 1 == COEFFS_PER_POLY);
                kept_count          = kept_count + 9'd1;
                n++;
            end
        end
        if (n > 0)
        begin
            kept[n-1].run_last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            coef_expect_q.push_back(kept[i]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        coef_item_t want;
        bit         bad;
        if (!rst_n)
        begin
            bound_q    = BOUND_RESET;
            kept_count = '0;
            coef_expect_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (coef_valid && !coef_stall)
            begin
                if (coef_expect_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: coefficient request with none expected, actual %0h idx %0d",
                             $time, coef_data.coefficient, coef_data.coeff_index);
                end
                else
                begin
                    want = coef_expect_q.pop_front();
                    bad  = 1'b0;
                    if (coef_data.coefficient !== want.coefficient)
                    begin
                        bad = 1'b1;
                        $display("%0t: coefficient expected %0h actual %0h",
                                 $time, want.coefficient, coef_data.coefficient);
                    end
                    if (coef_data.coeff_index !== want.coeff_index)
                    begin
                        bad = 1'b1;
                        $display("%0t: coeff_index expected %0d actual %0d",
                                 $time, want.coeff_index, coef_data.coeff_index);
                    end
                    if (coef_data.run_last !== want.run_last)
                    begin
                        bad = 1'b1;
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, want.run_last, coef_data.run_last);
                    end
                    if (coef_data.poly_done !== want.poly_done)
                    begin
                        bad = 1'b1;
                        $display("%0t: poly_done expected %0b actual %0b",
                                 $time, want.poly_done, coef_data.poly_done);
                    end
                    if (bad)
                    begin
                        mismatches++;
                    end
                end
            end
            if (cand_valid && !cand_stall)
            begin
                predict_coefficients(cand_data);
            end
            if (psel && penable && pwrite && pready
                && reg_idx_t'(paddr[APB_ADDR_W-1]) == REG_BOUND)
            begin
                bound_q = pwdata[BOUND_W-1:0];
            end
            outstanding = coef_expect_q.size();
        end
    end

endmodule

[tb/sv/tb_mod_q_rejection_sampler.sv]
`timescale 1ns / 1ps

module tb_mod_q_rejection_sampler;
    import mqrs_pkg::*;

    localparam int LANES           = 8;
    localparam int COEFFS_PER_POLY = 256;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [APB_ADDR_W-1:0] paddr      = '0;
    logic [APB_DATA_W-1:0] pwdata     = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  cand_valid = 1'b0;
    logic                  cand_stall;
    cand_item_t            cand_data  = '0;
    logic                  coef_valid;
    logic                  coef_stall = 1'b0;
    coef_item_t            coef_data;

    int                    mismatches;
    int                    outstanding;

    // bound as last written, used only to shape the candidates and tally the kept ones
    logic [BOUND_W-1:0]    cur_bound = BOUND_RESET;
    // random idling on both channels while set
    bit                    throttle  = 1'b1;

    mod_q_rejection_sampler #(
        .LANES           (LANES),
        .COEFFS_PER_POLY (COEFFS_PER_POLY)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .cand_valid (cand_valid),
        .cand_stall (cand_stall),
        .cand_data  (cand_data),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_data  (coef_data)
    );

    mqrs_coef_checker #(
        .LANES           (LANES),
        .COEFFS_PER_POLY (COEFFS_PER_POLY)
    ) coef_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .cand_valid  (cand_valid),
        .cand_stall  (cand_stall),
        .cand_data   (cand_data),
        .coef_valid  (coef_valid),
        .coef_stall  (coef_stall),
        .coef_data   (coef_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // coefficient side: a stall-free run, then now and then a stall burst, repeated
    initial
    begin
        @(posedge clk);
        forever
        begin
            coef_stall <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
            if (throttle && $urandom_range(0, 2) == 0)
            begin
                coef_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    // one candidate request, held until taken; an optional idle burst first
    task automatic send_request(input cand_item_t r);
        if (throttle && $urandom_range(0, 3) == 0)
        begin
            cand_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cand_valid <= 1'b1;
        cand_data  <= r;
        // stall read right after the edge is the value the block saw
        do @(posedge clk); while (cand_stall);
    endtask

    // bound write, only once every expected coefficient has left and any
    // request that keeps nothing has had time to pass through the drain
    task automatic set_bound(input logic [BOUND_W-1:0] value);
        cand_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BOUND, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_bound = value;
    endtask

    // random requests, mostly whole polynomials: a new_polynomial request,
    // then requests until about COEFFS_PER_POLY are kept, then a few that
    // must be dropped; now and then a polynomial restarts half way
    task automatic random_phase(input int n_items, input bit quiet);
        cand_item_t        r;
        logic [CAND_W-1:0] c [NUM_CAND];
        int                tally;
        int                extra;
        int                lanes;
        int                sel;
        bit                fresh;
        tally = COEFFS_PER_POLY;
        extra = 0;
        for (int k = 0; k < n_items; k++)
        begin
            // idling switches on and off in stretches
            if (k % 12 == 0)
            begin
                throttle = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
            end
            fresh = 1'b0;
            if (tally >= COEFFS_PER_POLY)
            begin
                if (extra == 0)
                begin
                    fresh = 1'b1;
                    tally = 0;
                    extra = $urandom_range(0, 3);
                end
                else
                begin
                    extra--;
                end
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                fresh = 1'b1;
                tally = 0;
            end
            for (int i = 0; i < NUM_CAND; i++)
            begin
                sel = $urandom_range(0, 19);
                case (sel)
                    0:       c[i] = cur_bound - 24'd1;
                    1:       c[i] = cur_bound;
                    2:       c[i] = cur_bound + 24'd1;
                    3:       c[i] = '0;
                    4:       c[i] = {1'b0, CAND_MASK};
                    default: c[i] = CAND_W'($urandom);
                endcase
                // the ignored top bit goes either way on the corner values
                if (sel < 5)
                begin
                    c[i][CAND_W-1] = 1'($urandom_range(0, 1));
                end
            end
            r.candidate_0      = c[0];
            r.candidate_1      = c[1];
            r.candidate_2      = c[2];
            r.candidate_3      = c[3];
            r.candidate_4      = c[4];
            r.candidate_5      = c[5];
            r.candidate_6      = c[6];
            r.candidate_7      = c[7];
            r.valid_candidates = ($urandom_range(0, 9) < 8) ? NCAND_W'(8)
                                                            : NCAND_W'($urandom_range(0, 15));
            // a stray new_polynomial now and then
            r.new_polynomial   = fresh | ($urandom_range(0, 49) == 0);
            if (r.new_polynomial)
            begin
                tally = 0;
            end
            lanes = (r.valid_candidates > LANES) ? LANES : int'(r.valid_candidates);
            for (int i = 0; i < lanes; i++)
            begin
                if ((c[i] & CAND_MASK) < cur_bound)
                begin
                    tally++;
                end
            end
            send_request(r);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at the reset bound 0x7fe001
        // all zero candidates, new polynomial: eight coefficients of zero
        send_request({{8{24'h000000}}, 4'd8, 1'b1});
        // all ones mask to 0x7fffff, above the bound: nothing kept
        send_request({{8{24'hFFFFFF}}, 4'd8, 1'b0});
        // around the bound, top bit set and clear
        send_request({24'h7FE000, 24'h7FE001, 24'hFFE000, 24'hFFE001,
                      24'h7FE002, 24'h800000, 24'h7FFFFF, 24'h000001, 4'd8, 1'b0});
        // zero valid candidates: no coefficient
        send_request({{8{24'h123456}}, 4'd0, 1'b0});
        // count above the lane number is clipped to eight
        send_request({{8{24'h5A5A5A}}, 4'd15, 1'b0});
        send_request({{8{24'hA5A5A5}}, 4'd9, 1'b0});
        // a single valid lane, the rest must be ignored
        send_request({24'h000010, {7{24'h000020}}, 4'd1, 1'b0});
        // new polynomial in the middle restarts the index
        send_request({24'h0ABCDE, 24'h7FE001, 24'h3FFFFF, {5{24'h000033}}, 4'd3, 1'b1});

        random_phase(45, 1'b0);

        // bound zero rejects everything
        set_bound(24'h000000);
        send_request({{8{24'h000000}}, 4'd8, 1'b1});
        random_phase(5, 1'b0);

        // bound one keeps only masked zeros
        set_bound(24'h000001);
        send_request({24'h800000, 24'h000000, 24'h000001, 24'h7FFFFF,
                      24'h800001, 24'h000000, 24'hFFFFFF, 24'h800000, 4'd8, 1'b1});
        random_phase(8, 1'b0);

        // bound 0x800000, the smallest that keeps every masked value
        set_bound(24'h800000);
        send_request({{8{24'h7FFFFF}}, 4'd8, 1'b1});
        random_phase(40, 1'b0);

        set_bound(24'hFFFFFF);
        random_phase(30, 1'b0);

        set_bound(BOUND_W'($urandom_range(24'h400000, 24'h7FFFFF)));
        random_phase(35, 1'b0);

        // last stretch back at the reset bound, no idling on either side
        set_bound(BOUND_RESET);
        random_phase(40, 1'b1);

        cand_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        // let any request that keeps nothing pass through as well
        repeat (16) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, many times the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/mqrs_pkg.sv
rtl/core/mqrs_screen.sv
rtl/core/mqrs_drain.sv
rtl/core/mod_q_rejection_sampler.sv
tb/sv/mqrs_coef_checker.sv
tb/sv/tb_mod_q_rejection_sampler.sv
